// File: rtl/phh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_pkg
// Shared types and codes of the price priority heap: heap entry, sibling row
// of one heap level, memory strobes and status codes.
// ----------------------------------------------------------------------------
package phh_pkg;

    localparam int PRICE_W  = 32;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic ORDER_MAX = 1'b0;

    typedef struct packed {
        logic [PRICE_W-1:0]  price;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    // two siblings of one level: slot 0 is the left child, slot 1 the right
    typedef t_entry [1:0] t_row;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    // true if price a must sit above price b
    function automatic logic ranks_above(input logic [PRICE_W-1:0] a,
                                         input logic [PRICE_W-1:0] b,
                                         input logic order);
        logic res;
        if (order == ORDER_MAX) begin
            res = (a > b);
        end else begin
            res = (a < b);
        end
        return res;
    endfunction

endpackage

// File: rtl/phh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_if
// Valid/ready channels of the price priority heap: command beats in, result
// beats out, and the order configuration write.
// ----------------------------------------------------------------------------
interface phh_in_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic [phh_pkg::PRICE_W-1:0]       new_price;
    logic [phh_pkg::HANDLE_W-1:0]      new_handle;

    modport source (output valid, mode, new_price, new_handle, input ready);
    modport sink   (input valid, mode, new_price, new_handle, output ready);
endinterface

interface phh_out_if;
    logic                              valid;
    logic                              ready;
    logic [phh_pkg::STATUS_W-1:0]      status;
    logic [phh_pkg::PRICE_W-1:0]       popped_price;
    logic [phh_pkg::HANDLE_W-1:0]      popped_handle;
    logic                              top_valid;
    logic [phh_pkg::PRICE_W-1:0]       top_price;
    logic [phh_pkg::HANDLE_W-1:0]      top_handle;
    logic [phh_pkg::TOTAL_W-1:0]       entry_total;

    modport source (output valid, status, popped_price, popped_handle, top_valid,
                    top_price, top_handle, entry_total, input ready);
    modport sink   (input valid, status, popped_price, popped_handle, top_valid,
                    top_price, top_handle, entry_total, output ready);
endinterface

interface phh_cfg_if;
    logic valid;
    logic ready;
    logic heap_order;

    modport source (output valid, heap_order, input ready);
    modport sink   (input valid, heap_order, output ready);
endinterface

// File: rtl/phh_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_level
// One level of the heap below the root: a memory of sibling rows with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module phh_level #(
    parameter int ROWS   = 1,
    parameter int ADDR_W = 6
) (
    input  logic                       i_clk,
    input  phh_pkg::t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  phh_pkg::t_row              i_wr_row,
    output phh_pkg::t_row              o_rd_row
);

    localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH = 1 << AW;

    phh_pkg::t_row r_mem [0:DEPTH-1];
    phh_pkg::t_row r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr[AW-1:0]] <= i_wr_row;
        end
        if (i_ctl.rd) begin
            r_rd_row <= r_mem[i_rd_addr[AW-1:0]];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// File: rtl/price_priority_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_priority_heap
// Binary heap of price/handle entries, max or min on top. The root sits in a
// register and each level below it in one memory cell; sifts walk level by level.
//
//  channel   dir  beat contents                                     accept
//  i_in      in   mode, new_price, new_handle                       valid & ready
//  o_out     out  status, popped_*, top_*, entry_total              valid & ready
//  i_cfg     in   heap_order                                        valid & ready
//
// Each sift step reads the rows, then compares and writes back. A push walks up
// from the new tail slot; a pop reads the last entry and sifts it down from the root.
// Refused commands, a push into an empty heap and a pop that empties it go
// straight to the result load. One command is in flight at a time; the next is
// taken while the result beat waits in the output register, and a stalled o_out
// then holds the finished command before its result load. Reset clears the
// count and order and holds both inputs off; memories hold garbage until
// written and only filled slots are ever used.
// ----------------------------------------------------------------------------
module price_priority_heap #(
    parameter int CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    phh_in_if.sink           i_in,
    phh_out_if.source        o_out,
    phh_cfg_if.sink          i_cfg
);

    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam int LW     = $clog2(LEVELS);
    localparam int PW     = LEVELS - 1;
    localparam int CW     = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UP_RD  = 8'b0000_0010,
        S_UP_DEC = 8'b0000_0100,
        S_POP_RD = 8'b0000_1000,
        S_POP_LD = 8'b0001_0000,
        S_DN_RD  = 8'b0010_0000,
        S_DN_DEC = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_fill, n_fill;
    logic [LW-1:0]                   r_tail_lvl, n_tail_lvl;
    logic [PW-1:0]                   r_tail_pos, n_tail_pos;
    logic                            r_order;
    logic                            r_ovalid, n_ovalid;
    phh_pkg::t_entry                 r_root, n_root;
    phh_pkg::t_entry                 r_x, n_x;
    phh_pkg::t_entry                 r_pop, n_pop;
    logic [LW-1:0]                   r_lvl, n_lvl;
    logic [PW-1:0]                   r_pos, n_pos;
    logic [CW-1:0]                   r_g, n_g;
    logic [phh_pkg::STATUS_W-1:0]    r_status, n_status;

    logic [phh_pkg::STATUS_W-1:0]    r_o_status;
    phh_pkg::t_entry                 r_o_pop;
    logic                            r_o_top_valid;
    phh_pkg::t_entry                 r_o_top;
    logic [phh_pkg::TOTAL_W-1:0]     r_o_total;
    logic                            w_load;

    phh_pkg::t_row                   w_rd_row [1:LEVELS-1];
    phh_pkg::t_row                   w_own, w_par, w_kid, w_tail;
    phh_pkg::t_row                   w_wr_row;
    phh_pkg::t_entry                 w_par_ent, w_wr_val, w_best;
    logic [PW-1:0]                   w_pos_sh1, w_pos_sh2;
    logic                            w_up_swap, w_dn_move, w_side;
    logic                            w_left_ok, w_right_ok;
    logic [CW:0]                     w_left_g, w_right_g;
    logic                            w_in_acc;

    function automatic logic [PW-1:0] level_last(input logic [LW-1:0] lvl);
        logic [PW:0] span;
        span = (PW + 1)'(1) << lvl;
        return PW'(span - (PW + 1)'(1));
    endfunction

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign i_cfg.ready = i_rst_n;

    assign w_pos_sh1 = r_pos >> 1;
    assign w_pos_sh2 = r_pos >> 2;

    // pick the registered rows of the cells around the active level and at the tail
    always_comb begin
        w_own  = '0;
        w_par  = '0;
        w_kid  = '0;
        w_tail = '0;
        for (int i = 1; i < LEVELS; i++) begin
            if (LW'(i) == r_lvl) begin
                w_own = w_rd_row[i];
            end
            if (LW'(i) == r_lvl - LW'(1)) begin
                w_par = w_rd_row[i];
            end
            if (LW'(i) == r_lvl + LW'(1)) begin
                w_kid = w_rd_row[i];
            end
            if (LW'(i) == r_tail_lvl) begin
                w_tail = w_rd_row[i];
            end
        end
    end

    // sift decisions
    always_comb begin
        w_par_ent = (r_lvl == LW'(1)) ? r_root : w_par[w_pos_sh1[0]];
        w_up_swap = phh_pkg::ranks_above(r_x.price, w_par_ent.price, r_order);

        w_left_g   = {r_g, 1'b1};
        w_right_g  = w_left_g + (CW + 1)'(1);
        w_left_ok  = (w_left_g < {1'b0, r_fill});
        w_right_ok = (w_right_g < {1'b0, r_fill});
        w_best     = r_x;
        w_side     = 1'b0;
        w_dn_move  = 1'b0;
        if (w_left_ok && phh_pkg::ranks_above(w_kid[0].price, w_best.price, r_order)) begin
            w_best    = w_kid[0];
            w_dn_move = 1'b1;
        end
        if (w_right_ok && phh_pkg::ranks_above(w_kid[1].price, w_best.price, r_order)) begin
            w_best    = w_kid[1];
            w_side    = 1'b1;
            w_dn_move = 1'b1;
        end

        if (r_state == S_UP_DEC) begin
            w_wr_val = w_up_swap ? w_par_ent : r_x;
        end else begin
            w_wr_val = w_best;
        end
        w_wr_row            = w_own;
        w_wr_row[r_pos[0]]  = w_wr_val;
    end

    // level cells
    for (genvar gi = 1; gi < LEVELS; gi++) begin : g_level
        localparam int SPAN  = 1 << gi;
        localparam int LEFT  = CAPACITY - SPAN + 1;
        localparam int NENT  = (SPAN < LEFT) ? SPAN : LEFT;
        localparam int NROWS = (NENT + 1) / 2;

        phh_pkg::t_mem_ctl w_ctl;
        logic [PW-1:0]     w_rd_addr;

        always_comb begin
            w_ctl.rd  = 1'b0;
            w_rd_addr = w_pos_sh1;
            case (r_state)
                S_UP_RD: begin
                    w_ctl.rd  = (LW'(gi) == r_lvl) || (LW'(gi) == r_lvl - LW'(1));
                    w_rd_addr = (LW'(gi) == r_lvl) ? w_pos_sh1 : w_pos_sh2;
                end
                S_DN_RD: begin
                    w_ctl.rd  = (LW'(gi) == r_lvl) || (LW'(gi) == r_lvl + LW'(1));
                    w_rd_addr = (LW'(gi) == r_lvl) ? w_pos_sh1 : r_pos;
                end
                S_POP_RD: begin
                    w_ctl.rd  = (LW'(gi) == r_tail_lvl);
                    w_rd_addr = r_tail_pos >> 1;
                end
                default: begin
                    w_ctl.rd = 1'b0;
                end
            endcase
            w_ctl.wr = ((r_state == S_UP_DEC) || (r_state == S_DN_DEC))
                       && (LW'(gi) == r_lvl);
        end

        phh_level #(
            .ROWS   (NROWS),
            .ADDR_W (PW)
        ) u_level (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_rd_addr (w_rd_addr),
            .i_wr_addr (w_pos_sh1),
            .i_wr_row  (w_wr_row),
            .o_rd_row  (w_rd_row[gi])
        );
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_tail_lvl = r_tail_lvl;
        n_tail_pos = r_tail_pos;
        n_root     = r_root;
        n_x        = r_x;
        n_pop      = r_pop;
        n_lvl      = r_lvl;
        n_pos      = r_pos;
        n_g        = r_g;
        n_status   = r_status;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_pop    = '0;
                    n_status = phh_pkg::ST_OK;
                    if (i_in.mode == phh_pkg::MODE_PUSH) begin
                        if (r_fill == CW'(CAPACITY)) begin
                            n_status = phh_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_fill     = r_fill + CW'(1);
                            n_x.price  = i_in.new_price;
                            n_x.handle = i_in.new_handle;
                            n_lvl      = r_tail_lvl;
                            n_pos      = r_tail_pos;
                            if (r_tail_pos == level_last(r_tail_lvl)) begin
                                n_tail_lvl = r_tail_lvl + LW'(1);
                                n_tail_pos = '0;
                            end else begin
                                n_tail_pos = r_tail_pos + PW'(1);
                            end
                            if (r_tail_lvl == '0) begin
                                n_root.price  = i_in.new_price;
                                n_root.handle = i_in.new_handle;
                                n_state       = S_DONE;
                            end else begin
                                n_state = S_UP_RD;
                            end
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_status = phh_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_pop  = r_root;
                            n_fill = r_fill - CW'(1);
                            if (r_tail_pos == '0) begin
                                n_tail_lvl = r_tail_lvl - LW'(1);
                                n_tail_pos = level_last(r_tail_lvl - LW'(1));
                            end else begin
                                n_tail_pos = r_tail_pos - PW'(1);
                            end
                            n_state = (r_fill == CW'(1)) ? S_DONE : S_POP_RD;
                        end
                    end
                end
            end
            S_POP_RD: begin
                n_state = S_POP_LD;
            end
            S_POP_LD: begin
                // last entry becomes the carried entry, sift from the root
                n_x     = w_tail[r_tail_pos[0]];
                n_lvl   = '0;
                n_pos   = '0;
                n_g     = '0;
                n_state = S_DN_RD;
            end
            S_UP_RD: begin
                n_state = S_UP_DEC;
            end
            S_UP_DEC: begin
                if (w_up_swap) begin
                    n_lvl = r_lvl - LW'(1);
                    n_pos = w_pos_sh1;
                    if (r_lvl == LW'(1)) begin
                        n_root  = r_x;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_UP_RD;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_RD: begin
                n_state = S_DN_DEC;
            end
            S_DN_DEC: begin
                if (r_lvl == '0) begin
                    n_root = w_wr_val;
                end
                if (w_dn_move) begin
                    n_lvl   = r_lvl + LW'(1);
                    n_pos   = PW'({r_pos, w_side});
                    n_g     = CW'(w_left_g + (CW + 1)'(w_side));
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end
        if (w_load) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_tail_lvl <= '0;
            r_tail_pos <= '0;
            r_order    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_tail_lvl <= n_tail_lvl;
            r_tail_pos <= n_tail_pos;
            r_ovalid   <= n_ovalid;
            if (i_cfg.valid) begin
                r_order <= i_cfg.heap_order;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_root   <= n_root;
        r_x      <= n_x;
        r_pop    <= n_pop;
        r_lvl    <= n_lvl;
        r_pos    <= n_pos;
        r_g      <= n_g;
        r_status <= n_status;
        if (w_load) begin
            r_o_status    <= r_status;
            r_o_pop       <= r_pop;
            r_o_top_valid <= (r_fill != '0);
            r_o_top       <= (r_fill != '0) ? r_root : '0;
            r_o_total     <= (phh_pkg::TOTAL_W)'(r_fill);
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_o_status;
    assign o_out.popped_price  = r_o_pop.price;
    assign o_out.popped_handle = r_o_pop.handle;
    assign o_out.top_valid     = r_o_top_valid;
    assign o_out.top_price     = r_o_top.price;
    assign o_out.top_handle    = r_o_top.handle;
    assign o_out.entry_total   = r_o_total;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("heap count beyond capacity");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.mode == phh_pkg::MODE_PUSH) && (r_fill != CW'(CAPACITY)))
        |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("accepted push did not raise the count");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.mode == phh_pkg::MODE_POP) && (r_fill != '0))
        |=> (r_fill == $past(r_fill) - CW'(1)))
        else $error("accepted pop did not lower the count");

    a_sift_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DN_DEC) || (r_state == S_UP_DEC)) |-> (r_lvl <= LW'(LEVELS - 1)))
        else $error("sift walked past the last level");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_ovalid) |=> (r_ovalid && (r_state == S_IDLE)))
        else $error("finished command not loaded into the output register");

endmodule
